// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while reset is low
`define LSC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define LSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lsc_pkg.sv =====
// types, codes and constants of the locking script classifier
`default_nettype none

package lsc_pkg;

  localparam int MAX_PUSH_BYTES_DEFAULT = 10000;

  localparam int BYTE_W  = 8;
  localparam int POS_W   = 6;
  localparam int PUSH_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int KIND_W  = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RETURN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUP         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HASH        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EQUALVERIFY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHECKSIG    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PUSH_ONE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PUSH_TWO    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PUSH_FOUR   = 3'd7;

  // script kinds
  localparam logic [KIND_W-1:0] KIND_NONSTANDARD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAY_TO_HASH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NULL_DATA   = 2'd2;

  // fixed opcodes
  localparam logic [BYTE_W-1:0] OP_ZERO         = 8'h00;
  localparam logic [BYTE_W-1:0] DIRECT_PUSH_MIN = 8'h01;
  localparam logic [BYTE_W-1:0] DIRECT_PUSH_MAX = 8'h4b;
  localparam logic [BYTE_W-1:0] HASH_PUSH       = 8'h20;

  // template positions
  localparam logic [POS_W-1:0] POS_DUP        = 6'd0;
  localparam logic [POS_W-1:0] POS_HASH_OP    = 6'd1;
  localparam logic [POS_W-1:0] POS_HASH_PUSH  = 6'd2;
  localparam logic [POS_W-1:0] POS_HASH_FIRST = 6'd3;
  localparam logic [POS_W-1:0] POS_HASH_LAST  = 6'd34;
  localparam logic [POS_W-1:0] POS_EQUALVERIFY = 6'd35;
  localparam logic [POS_W-1:0] POS_CHECKSIG   = 6'd36;
  localparam logic [POS_W-1:0] TEMPLATE_LEN   = 6'd37;
  localparam logic [POS_W-1:0] POS_SATURATE   = 6'd38;

  // length byte counts of the pushdata opcodes
  localparam logic [2:0] LEN_ONE  = 3'd1;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  typedef enum logic [1:0] {
    PH_OPCODE,
    PH_LENGTH,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] return_code;
    logic [BYTE_W-1:0] dup_code;
    logic [BYTE_W-1:0] hash_code;
    logic [BYTE_W-1:0] equalverify_code;
    logic [BYTE_W-1:0] checksig_code;
    logic [BYTE_W-1:0] push_one_code;
    logic [BYTE_W-1:0] push_two_code;
    logic [BYTE_W-1:0] push_four_code;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    return_code:      8'd106,
    dup_code:         8'd118,
    hash_code:        8'd168,
    equalverify_code: 8'd136,
    checksig_code:    8'd172,
    push_one_code:    8'd76,
    push_two_code:    8'd77,
    push_four_code:   8'd78
  };

  typedef struct packed {
    logic [POS_W-1:0]  byte_position;
    logic              template_ok;
    logic              carrier_ok;
    phase_t            parse_phase;
    logic [2:0]        length_bytes_left;
    logic [1:0]        length_shift;
    logic [PUSH_W-1:0] push_remaining;
    logic              length_high;     // upper two length bytes not all zero
  } state_t;

  localparam state_t STATE_RESET = '{
    byte_position:     '0,
    template_ok:       1'b1,
    carrier_ok:        1'b1,
    parse_phase:       PH_OPCODE,
    length_bytes_left: '0,
    length_shift:      '0,
    push_remaining:    '0,
    length_high:       1'b0
  };

  typedef struct packed {
    state_t            next;
    logic              has_result;
    logic              data_valid;
    logic [BYTE_W-1:0] data_byte;
    logic              verdict_valid;
    logic [KIND_W-1:0] script_kind;
  } step_t;

endpackage

`default_nettype wire

// ===== rtl/lsc_step.sv =====
// per-byte update of the template matcher and the push parser
`default_nettype none

module lsc_step #(
  parameter int MAX_PUSH_BYTES = lsc_pkg::MAX_PUSH_BYTES_DEFAULT
) (
  input  lsc_pkg::state_t                 cur,
  input  lsc_pkg::cfg_t                   cfg,
  input  logic [lsc_pkg::BYTE_W-1:0]      b,
  input  logic                            present,
  input  logic                            last,
  output lsc_pkg::step_t                  res
);

  localparam logic [lsc_pkg::PUSH_W-1:0] MAX_PUSH = lsc_pkg::PUSH_W'(MAX_PUSH_BYTES);

  lsc_pkg::state_t              nxt;
  logic [lsc_pkg::POS_W-1:0]    pos;
  logic                         tmpl_data;
  logic                         carr_data;
  logic [lsc_pkg::PUSH_W-1:0]   acc_low;
  logic                         acc_high;
  logic [2:0]                   left_next;
  logic                         four;

  assign pos = cur.byte_position;

  always_comb begin
    nxt       = cur;
    tmpl_data = 1'b0;
    carr_data = 1'b0;
    acc_low   = cur.push_remaining;
    acc_high  = cur.length_high;
    left_next = cur.length_bytes_left - 3'd1;
    four      = (cur.length_shift == 2'd3);

    if (present) begin
      // template matcher
      if (cur.template_ok) begin
        if (pos >= lsc_pkg::POS_HASH_FIRST && pos <= lsc_pkg::POS_HASH_LAST) begin
          tmpl_data = 1'b1;
        end else if ((pos == lsc_pkg::POS_DUP && b != cfg.dup_code) ||
                     (pos == lsc_pkg::POS_HASH_OP && b != cfg.hash_code) ||
                     (pos == lsc_pkg::POS_HASH_PUSH && b != lsc_pkg::HASH_PUSH) ||
                     (pos == lsc_pkg::POS_EQUALVERIFY && b != cfg.equalverify_code) ||
                     (pos == lsc_pkg::POS_CHECKSIG && b != cfg.checksig_code) ||
                     pos >= lsc_pkg::TEMPLATE_LEN) begin
          nxt.template_ok = 1'b0;
        end
      end

      // push parser
      if (pos == lsc_pkg::POS_DUP) begin
        nxt.carrier_ok = (b == cfg.return_code);
      end else if (cur.carrier_ok) begin
        case (cur.parse_phase)
          lsc_pkg::PH_PAYLOAD: begin
            carr_data          = 1'b1;
            nxt.push_remaining = cur.push_remaining - lsc_pkg::PUSH_W'(1);
            if (cur.push_remaining == lsc_pkg::PUSH_W'(1)) begin
              nxt.parse_phase = lsc_pkg::PH_OPCODE;
            end
          end
          lsc_pkg::PH_LENGTH: begin
            case (cur.length_shift)
              2'd0:    acc_low[7:0]  = cur.push_remaining[7:0] | b;
              2'd1:    acc_low[15:8] = cur.push_remaining[15:8] | b;
              default: acc_high      = cur.length_high | (b != 8'd0);
            endcase
            nxt.push_remaining    = acc_low;
            nxt.length_high       = acc_high;
            nxt.length_shift      = cur.length_shift + 2'd1;
            nxt.length_bytes_left = left_next;
            if (left_next == 3'd0) begin
              if (four && (acc_high || acc_low > MAX_PUSH)) begin
                nxt.carrier_ok = 1'b0;
              end else if (acc_low == '0 && !acc_high) begin
                nxt.parse_phase = lsc_pkg::PH_OPCODE;
              end else begin
                nxt.parse_phase = lsc_pkg::PH_PAYLOAD;
              end
            end
          end
          lsc_pkg::PH_OPCODE: begin
            if (b >= lsc_pkg::DIRECT_PUSH_MIN && b <= lsc_pkg::DIRECT_PUSH_MAX) begin
              nxt.push_remaining = lsc_pkg::PUSH_W'(b);
              nxt.length_high    = 1'b0;
              nxt.parse_phase    = lsc_pkg::PH_PAYLOAD;
            end else if (b == cfg.push_one_code || b == cfg.push_two_code ||
                         b == cfg.push_four_code) begin
              nxt.length_bytes_left = (b == cfg.push_one_code) ? lsc_pkg::LEN_ONE :
                                      (b == cfg.push_two_code) ? lsc_pkg::LEN_TWO :
                                                                 lsc_pkg::LEN_FOUR;
              nxt.length_shift   = 2'd0;
              nxt.push_remaining = '0;
              nxt.length_high    = 1'b0;
              nxt.parse_phase    = lsc_pkg::PH_LENGTH;
            end else if (b != lsc_pkg::OP_ZERO) begin
              nxt.carrier_ok = 1'b0;
            end
          end
          default: begin
            nxt.parse_phase = cur.parse_phase;
          end
        endcase
      end

      if (pos < lsc_pkg::POS_SATURATE) begin
        nxt.byte_position = pos + 6'd1;
      end
    end

    res.data_valid    = tmpl_data | carr_data;
    res.data_byte     = (tmpl_data | carr_data) ? b : '0;
    res.verdict_valid = last;
    res.has_result    = tmpl_data | carr_data | last;
    res.script_kind   = lsc_pkg::KIND_NONSTANDARD;

    if (last) begin
      if (nxt.template_ok && nxt.byte_position == lsc_pkg::TEMPLATE_LEN) begin
        res.script_kind = lsc_pkg::KIND_PAY_TO_HASH;
      end else if (nxt.carrier_ok && nxt.byte_position != '0 &&
                   nxt.parse_phase == lsc_pkg::PH_OPCODE) begin
        res.script_kind = lsc_pkg::KIND_NULL_DATA;
      end
      nxt = lsc_pkg::STATE_RESET;
    end

    res.next = nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/locking_script_classifier.sv =====
// top level of the locking script classifier
//
// input channel: one script byte per beat (in_valid / in_stall), with
//   byte_present low for a beat that carries no byte and end_of_script high
//   on the beat that closes the script
// output channel: one beat per input beat that yields a hash or payload byte
//   or closes the script (out_valid / out_stall); other input beats give none
// data_valid marks a tentative data byte; verdict_valid marks the closing
//   beat, which carries script_kind; the consumer drops the data of a script
//   whose verdict is nonstandard
// path: the input register takes the beat, and the result register then
//   loads its result once free (input register, then result register)
// throughput: one byte per cycle unless out_stall holds a result; the only
//   loop is the parser state update between the input and result registers
// stall: while out_stall holds a result, the input register keeps its beat
//   and in_stall rises once that register is full; nothing is lost
// reset: rst clears the pipeline valids, the parser state and the opcode
//   registers to their defaults; configuration writes go through cfg_write
//   and must be made by the user while the block is idle (not enforced)
`default_nettype none

module locking_script_classifier #(
  parameter int MAX_PUSH_BYTES = lsc_pkg::MAX_PUSH_BYTES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_write,
  input  logic [lsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lsc_pkg::BYTE_W-1:0]         cfg_data,
  // script bytes
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lsc_pkg::BYTE_W-1:0]         script_byte,
  input  logic                               byte_present,
  input  logic                               end_of_script,
  // results
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               data_valid,
  output logic [lsc_pkg::BYTE_W-1:0]         data_byte,
  output logic                               verdict_valid,
  output logic [lsc_pkg::KIND_W-1:0]         script_kind
);

  lsc_pkg::cfg_t                cfg;
  lsc_pkg::state_t              state;
  lsc_pkg::step_t               step;

  // input register
  logic                         in_full;
  logic [lsc_pkg::BYTE_W-1:0]   in_byte;
  logic                         in_present;
  logic                         in_last;

  logic                         out_free;

  // result register can take a new value when empty or being drained
  assign out_free = !out_valid || !out_stall;
  assign in_stall = in_full && !out_free;

  lsc_step #(
    .MAX_PUSH_BYTES (MAX_PUSH_BYTES)
  ) u_step (
    .cur     (state),
    .cfg     (cfg),
    .b       (in_byte),
    .present (in_present),
    .last    (in_last),
    .res     (step)
  );

  // control: valids, parser state and opcode registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      state     <= lsc_pkg::STATE_RESET;
      cfg       <= lsc_pkg::CFG_RESET;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          lsc_pkg::REG_RETURN:      cfg.return_code      <= cfg_data;
          lsc_pkg::REG_DUP:         cfg.dup_code         <= cfg_data;
          lsc_pkg::REG_HASH:        cfg.hash_code        <= cfg_data;
          lsc_pkg::REG_EQUALVERIFY: cfg.equalverify_code <= cfg_data;
          lsc_pkg::REG_CHECKSIG:    cfg.checksig_code    <= cfg_data;
          lsc_pkg::REG_PUSH_ONE:    cfg.push_one_code    <= cfg_data;
          lsc_pkg::REG_PUSH_TWO:    cfg.push_two_code    <= cfg_data;
          lsc_pkg::REG_PUSH_FOUR:   cfg.push_four_code   <= cfg_data;
          default:                  cfg                  <= cfg;
        endcase
      end
      // input register refills whenever its beat moves on or it is empty
      if (!in_stall) begin
        in_full <= in_valid;
      end
      // the held beat is processed in the cycle it moves to the result side
      if (out_free) begin
        out_valid <= in_full && step.has_result;
        if (in_full) begin
          state <= step.next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte    <= script_byte;
      in_present <= byte_present;
      in_last    <= end_of_script;
    end
    if (out_free && in_full) begin
      data_valid    <= step.data_valid;
      data_byte     <= step.data_byte;
      verdict_valid <= step.verdict_valid;
      script_kind   <= step.script_kind;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lsc_checker.sv =====
// port-level checker of the locking script classifier, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module lsc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          data_valid,
  input logic [lsc_pkg::BYTE_W-1:0]    data_byte,
  input logic                          verdict_valid,
  input logic [lsc_pkg::KIND_W-1:0]    script_kind
);

  // a held result keeps its payload
  `LSC_ASSERT(a_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(data_valid) && $stable(data_byte) && $stable(verdict_valid) && $stable(script_kind), "stalled result changed")

  // every result beat carries data or a verdict
  `LSC_ASSERT(a_nonempty, clk, rst, out_valid |-> data_valid || verdict_valid, "empty result beat")

  // kind is only reported on the closing beat
  `LSC_ASSERT(a_kind, clk, rst, out_valid && !verdict_valid |-> script_kind == lsc_pkg::KIND_NONSTANDARD, "kind without verdict")

  // data byte is zero when no data is marked
  `LSC_ASSERT(a_zero, clk, rst, out_valid && !data_valid |-> data_byte == 8'd0, "stray data byte")

  // reset empties the result register
  `LSC_ASSERT_ALWAYS(a_reset, clk, rst |=> !out_valid, "result after reset")

endmodule

bind locking_script_classifier lsc_checker u_lsc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .data_valid    (data_valid),
  .data_byte     (data_byte),
  .verdict_valid (verdict_valid),
  .script_kind   (script_kind)
);

`default_nettype wire
